// ===== hw/rtl/rwr_pkg.sv =====
// ----------------------------------------------------------------------------
// rwr_pkg
// Shared types and constants for the Ethernet/IPv4 address rewriter.
// ----------------------------------------------------------------------------
package rwr_pkg;

  localparam int unsigned HdrLen  = 34;
  localparam int unsigned PosW    = 6;
  localparam int unsigned AddrW   = 48;
  localparam int unsigned IpW     = 32;
  localparam int unsigned AccW    = 20;
  localparam int unsigned CfgAw   = 5;
  localparam int unsigned CfgDw   = 64;

  localparam logic [PosW-1:0] DmacAt  = 6'd0;
  localparam logic [PosW-1:0] SmacAt  = 6'd6;
  localparam logic [PosW-1:0] IpStart = 6'd14;
  localparam logic [PosW-1:0] CsumAt  = 6'd24;
  localparam logic [PosW-1:0] SipAt   = 6'd26;
  localparam logic [PosW-1:0] DipAt   = 6'd30;
  localparam logic [PosW-1:0] HdrEnd  = 6'd33;

  localparam int unsigned EnSip  = 0;
  localparam int unsigned EnDip  = 1;
  localparam int unsigned EnSmac = 2;
  localparam int unsigned EnDmac = 3;

  typedef enum logic [1:0] {
    REG_ENABLES = 2'd0,
    REG_OLD     = 2'd1,
    REG_NEW     = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CAPT,
    ST_MATCH,
    ST_SUM,
    ST_FOLD,
    ST_READ,
    ST_LOAD,
    ST_PASS
  } state_t;

  typedef struct packed {
    logic            cap;
    logic [PosW-1:0] pos;
    logic            fix_match;
    logic            fix_sum;
    logic            fix_fold;
    logic            rd;
    logic [PosW-1:0] rd_addr;
    logic            ld_rel;
    logic            ld_pass;
    logic            last;
    logic            full;
  } dp_cmd_t;

endpackage

// ===== hw/rtl/rwr_ifs.sv =====
// ----------------------------------------------------------------------------
// rwr_ifs
// Valid/ready stream interfaces for frame bytes in and rewritten bytes out.
// ----------------------------------------------------------------------------
interface rwr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface rwr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hw/rtl/rwr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rwr_cfg_regs
// APB-style register block: rewrite enables, old address, new address.
// ----------------------------------------------------------------------------
module rwr_cfg_regs
  import rwr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [CfgAw-1:0] paddr,
  input  logic [CfgDw-1:0] pwdata,
  output logic [CfgDw-1:0] prdata,
  output logic             pready,
  output logic [3:0]       rewrite_enables,
  output logic [AddrW-1:0] old_addr,
  output logic [AddrW-1:0] new_addr
);

  logic [3:0]       enables_r;
  logic [AddrW-1:0] old_addr_r;
  logic [AddrW-1:0] new_addr_r;
  logic             wr;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enables_r  <= '0;
      old_addr_r <= '0;
      new_addr_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_ENABLES: enables_r  <= pwdata[3:0];
        REG_OLD:     old_addr_r <= pwdata[AddrW-1:0];
        REG_NEW:     new_addr_r <= pwdata[AddrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLES: prdata = {{(CfgDw-4){1'b0}}, enables_r};
      REG_OLD:     prdata = {{(CfgDw-AddrW){1'b0}}, old_addr_r};
      REG_NEW:     prdata = {{(CfgDw-AddrW){1'b0}}, new_addr_r};
      default:     prdata = '0;
    endcase
  end

  assign rewrite_enables = enables_r;
  assign old_addr        = old_addr_r;
  assign new_addr        = new_addr_r;

endmodule

// ===== hw/rtl/rwr_datapath.sv =====
// ----------------------------------------------------------------------------
// rwr_datapath
// Header buffer, address field registers, checksum unit and output register.
// ----------------------------------------------------------------------------
module rwr_datapath
  import rwr_pkg::*;
(
  input  logic             clk,
  input  dp_cmd_t          cmd,
  input  logic [7:0]       in_byte,
  input  logic [3:0]       rewrite_enables,
  input  logic [AddrW-1:0] old_addr,
  input  logic [AddrW-1:0] new_addr,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  logic [7:0]       mem [HdrLen];
  logic [7:0]       rdata_r;
  logic [AddrW-1:0] dmac_r;
  logic [AddrW-1:0] smac_r;
  logic [IpW-1:0]   sip_r;
  logic [IpW-1:0]   dip_r;
  logic [7:0]       hi_r;
  logic [AccW-1:0]  acc_r;
  logic [AccW-1:0]  sum_r;
  logic [15:0]      csum_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic             csum_en;
  logic [AccW-1:0]  sum_nxt;
  logic [16:0]      fold1;
  logic [16:0]      fold2;
  logic [PosW-1:0]  k;
  logic [PosW-1:0]  off;
  logic [AddrW-1:0] mac_sh;
  logic [IpW-1:0]   ip_sh;
  logic [7:0]       rel_byte;

  assign csum_en = rewrite_enables[EnSip] | rewrite_enables[EnDip];

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mem[cmd.pos] <= in_byte;
    end
    if (cmd.rd) begin
      rdata_r <= mem[cmd.rd_addr];
    end
  end

  assign sum_nxt = acc_r
                 + AccW'(sip_r[31:16]) + AccW'(sip_r[15:0])
                 + AccW'(dip_r[31:16]) + AccW'(dip_r[15:0]);
  assign fold1   = 17'(sum_r[15:0]) + 17'(sum_r[AccW-1:16]);
  assign fold2   = 17'(fold1[15:0]) + 17'(fold1[16]);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      if (cmd.pos == DmacAt) begin
        acc_r <= '0;
      end
      if (cmd.pos < SmacAt) begin
        dmac_r <= {dmac_r[AddrW-9:0], in_byte};
      end else if (cmd.pos < SmacAt + 6'd6) begin
        smac_r <= {smac_r[AddrW-9:0], in_byte};
      end else if (cmd.pos >= IpStart && cmd.pos < CsumAt) begin
        if (!cmd.pos[0]) begin
          hi_r <= in_byte;
        end else begin
          acc_r <= acc_r + AccW'({hi_r, in_byte});
        end
      end else if (cmd.pos >= SipAt && cmd.pos < DipAt) begin
        sip_r <= {sip_r[IpW-9:0], in_byte};
      end else if (cmd.pos >= DipAt) begin
        dip_r <= {dip_r[IpW-9:0], in_byte};
      end
    end
    if (cmd.fix_match) begin
      if (rewrite_enables[EnSip] && sip_r == old_addr[IpW-1:0]) begin
        sip_r <= new_addr[IpW-1:0];
      end
      if (rewrite_enables[EnDip] && dip_r == old_addr[IpW-1:0]) begin
        dip_r <= new_addr[IpW-1:0];
      end
      if (rewrite_enables[EnSmac] && smac_r == old_addr) begin
        smac_r <= new_addr;
      end
      if (rewrite_enables[EnDmac] && dmac_r == old_addr) begin
        dmac_r <= new_addr;
      end
    end
    if (cmd.fix_sum) begin
      sum_r <= sum_nxt;
    end
    if (cmd.fix_fold) begin
      csum_r <= ~fold2[15:0];
    end
  end

  assign k = cmd.rd_addr;

  always_comb begin
    off      = '0;
    mac_sh   = '0;
    ip_sh    = '0;
    rel_byte = rdata_r;
    if (cmd.full) begin
      if (k < SmacAt) begin
        mac_sh   = dmac_r >> {3'd5 - k[2:0], 3'b000};
        rel_byte = mac_sh[7:0];
      end else if (k < SmacAt + 6'd6) begin
        off      = k - SmacAt;
        mac_sh   = smac_r >> {3'd5 - off[2:0], 3'b000};
        rel_byte = mac_sh[7:0];
      end else if (k == CsumAt && csum_en) begin
        rel_byte = csum_r[15:8];
      end else if (k == CsumAt + 6'd1 && csum_en) begin
        rel_byte = csum_r[7:0];
      end else if (k >= SipAt && k < DipAt) begin
        off      = k - SipAt;
        ip_sh    = sip_r >> {2'd3 - off[1:0], 3'b000};
        rel_byte = ip_sh[7:0];
      end else if (k >= DipAt) begin
        off      = k - DipAt;
        ip_sh    = dip_r >> {2'd3 - off[1:0], 3'b000};
        rel_byte = ip_sh[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_rel) begin
      out_byte_r <= rel_byte;
      out_last_r <= cmd.last;
    end else if (cmd.ld_pass) begin
      out_byte_r <= in_byte;
      out_last_r <= cmd.last;
    end
  end

  assign out_byte = out_byte_r;
  assign out_last = out_last_r;

endmodule

// ===== hw/rtl/rwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rwr_ctrl
// Frame sequencer: header capture, rewrite steps, header release, pass-through.
// ----------------------------------------------------------------------------
module rwr_ctrl
  import rwr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  state_t          state_r, state_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [PosW-1:0] cnt_r, cnt_nxt;
  logic [PosW-1:0] end_r, end_nxt;
  logic            last_r, last_nxt;
  logic            full_r, full_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            in_acc;
  logic            out_free;

  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CAPT;
      pos_r       <= '0;
      cnt_r       <= '0;
      end_r       <= '0;
      last_r      <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      end_r       <= end_nxt;
      last_r      <= last_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CAPT: begin
        if (in_acc) begin
          if (pos_r == HdrEnd) begin
            state_nxt = ST_MATCH;
          end else if (in_last) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_MATCH: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_FOLD;
      ST_FOLD:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          if (cnt_r == end_r) begin
            state_nxt = last_r ? ST_CAPT : ST_PASS;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_PASS: begin
        if (in_acc && in_last) begin
          state_nxt = ST_CAPT;
        end
      end
      default: state_nxt = ST_CAPT;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    last_nxt      = last_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.pos       = pos_r;
    cmd.rd_addr   = cnt_r;
    cmd.full      = full_r;
    cmd.last      = last_r & (cnt_r == end_r);
    case (state_r)
      ST_CAPT: begin
        in_ready = 1'b1;
        cmd.cap  = in_acc;
        if (in_acc) begin
          if (pos_r == HdrEnd) begin
            last_nxt = in_last;
            full_nxt = 1'b1;
            end_nxt  = HdrEnd;
            cnt_nxt  = '0;
            pos_nxt  = '0;
          end else if (in_last) begin
            last_nxt = 1'b1;
            full_nxt = 1'b0;
            end_nxt  = pos_r;
            cnt_nxt  = '0;
            pos_nxt  = '0;
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
      end
      ST_MATCH: cmd.fix_match = 1'b1;
      ST_SUM:   cmd.fix_sum   = 1'b1;
      ST_FOLD:  cmd.fix_fold  = 1'b1;
      ST_READ:  cmd.rd        = 1'b1;
      ST_LOAD: begin
        if (out_free) begin
          cmd.ld_rel    = 1'b1;
          out_valid_nxt = 1'b1;
          if (cnt_r != end_r) begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
      end
      ST_PASS: begin
        in_ready = out_free;
        cmd.last = in_last;
        if (in_acc) begin
          cmd.ld_pass   = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/eth_ipv4_address_rewriter_core.sv =====
// The 34 header bytes are held until the 34th arrives; rewrite and checksum
// take the match, sum and fold steps; each header byte leaves after a header
// buffer read and an output register load. Short frames skip the rewrite. After
// the header, one byte per cycle passes the output register unless it stalls.
// Reset (synchronous, rst_n low) clears the sequencer and configuration; the
// header buffer is not cleared, only bytes of the current frame are read.
// ----------------------------------------------------------------------------
// eth_ipv4_address_rewriter_core
// Rewrites MAC and IPv4 addresses in frame headers and fixes the IP checksum.
// ----------------------------------------------------------------------------
module eth_ipv4_address_rewriter_core
  import rwr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  rwr_in_if.sink           in_if,
  rwr_out_if.source        out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [CfgAw-1:0] paddr,
  input  logic [CfgDw-1:0] pwdata,
  output logic [CfgDw-1:0] prdata,
  output logic             pready
);

  dp_cmd_t          cmd;
  logic [3:0]       rewrite_enables;
  logic [AddrW-1:0] old_addr;
  logic [AddrW-1:0] new_addr;
  logic             in_ready;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;

  rwr_cfg_regs u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .rewrite_enables (rewrite_enables),
    .old_addr        (old_addr),
    .new_addr        (new_addr)
  );

  rwr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.in_last),
    .in_ready  (in_ready),
    .out_ready (out_if.ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rwr_datapath u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .in_byte         (in_if.in_byte),
    .rewrite_enables (rewrite_enables),
    .old_addr        (old_addr),
    .new_addr        (new_addr),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

  assign in_if.ready     = in_ready;
  assign out_if.valid    = out_valid;
  assign out_if.out_byte = out_byte;
  assign out_if.out_last = out_last;

endmodule
